// ===== sv/compressed_int_bit_encoder_macros.svh =====
// Assertion macros for the integer bit encoder.
// Each macro checks on the rising edge of clk and is switched off while rst_n is low.
`ifndef COMPRESSED_INT_BIT_ENCODER_MACROS_SVH
`define COMPRESSED_INT_BIT_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

// ===== sv/cie_pkg.sv =====
package cie_pkg;

    localparam int MAX_VALUE_BYTES = 8;
    localparam int STREAM_W        = 72;
    localparam int LEN_W           = 7;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef struct packed {
        logic                flush;
        logic [STREAM_W-1:0] bits;
        logic [LEN_W-1:0]    len;
    } cie_item_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } cie_back_state_t;

endpackage

// ===== sv/compressed_int_bit_encoder.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | in_valid / in_ready  | mode, value, size_bytes, is_signed
// output   | out_valid / out_ready| out_byte, last_of_item, end_of_stream
//
// An encode item codes to at most 65 bits; the back end sends one byte a cycle
// while out_ready is high. Per item it loads the item from the queue, sends each
// completed byte and then carries the leftover bits. A flush item sends any
// carried bits as one zero-padded byte. The queue of QUEUE_DEPTH items lets input
// transfers continue while the output is stalled. Reset clears the carried bits.
module compressed_int_bit_encoder
    import cie_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [63:0] value,
    input  logic [3:0]  size_bytes,
    input  logic        is_signed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_item,
    output logic        end_of_stream
);

    cie_item_t front_item;
    cie_item_t q_data;
    logic      q_valid;
    logic      q_ready;

    cie_front u_front
    (
        .mode       (mode),
        .value      (value),
        .size_bytes (size_bytes),
        .is_signed  (is_signed),
        .item       (front_item)
    );

    cie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    cie_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_item  (last_of_item),
        .end_of_stream (end_of_stream)
    );

endmodule

// ===== sv/cie_front.sv =====
module cie_front
    import cie_pkg::*;
(
    input  logic        mode,
    input  logic [63:0] value,
    input  logic [3:0]  size_bytes,
    input  logic        is_signed,
    output cie_item_t   item
);

    // The coded bits of one item are built left aligned, first bit in the top position.
    always_comb
    begin
        logic [3:0] sz;
        logic [2:0] k;
        logic [2:0] j;
        logic [2:0] ones;
        logic [3:0] hlen;
        logic [7:0] fill;
        logic [63:0] swapped;
        logic [8:0] tail;
        logic found;
        logic nib;

        if (size_bytes == 4'd0)
        begin
            sz = 4'd1;
        end
        else if (size_bytes > 4'(MAX_VALUE_BYTES))
        begin
            sz = 4'(MAX_VALUE_BYTES);
        end
        else
        begin
            sz = size_bytes;
        end
        k    = 3'(sz - 4'd1);
        fill = {8{is_signed}};

        for (int i = 0; i < 8; i++)
        begin
            swapped[63 - 8 * i -: 8] = value[8 * i +: 8];
        end

        j     = 3'd0;
        found = 1'b0;
        for (int i = 1; i < 8; i++)
        begin
            if (3'(i) <= k && value[8 * i +: 8] != fill)
            begin
                j     = 3'(i);
                found = 1'b1;
            end
        end

        ones = k - j;
        hlen = {1'b0, ones} + 4'd1;
        nib  = (value[7:4] == fill[7:4]);
        tail = nib ? {1'b1, value[3:0], 4'b0000} : {1'b0, value[7:0]};

        item.flush = (mode == MODE_FLUSH);
        if (mode == MODE_FLUSH)
        begin
            item.bits = '0;
            item.len  = '0;
        end
        else if (found)
        begin
            item.bits = {~(8'hFF >> ones), 64'b0} | ({swapped, 8'b0} >> hlen);
            item.len  = 7'(hlen) + 7'({j, 3'b000}) + 7'd8;
        end
        else
        begin
            item.bits = {~(8'hFF >> k), 64'b0} | ({tail, 63'b0} >> k);
            item.len  = 7'(k) + 7'd1 + (nib ? 7'd4 : 7'd8);
        end
    end

endmodule

// ===== sv/cie_queue.sv =====
module cie_queue
    import cie_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  cie_item_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output cie_item_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cie_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/cie_back.sv =====
module cie_back
    import cie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  cie_item_t  q_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_item,
    output logic       end_of_stream
);

    cie_back_state_t     state_reg;
    cie_back_state_t     state_next;
    logic [STREAM_W-1:0] sh_reg;
    logic [STREAM_W-1:0] sh_next;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    rem_next;
    logic                flush_reg;
    logic                flush_next;
    logic [6:0]          pend_reg;
    logic [6:0]          pend_next;
    logic [2:0]          pcnt_reg;
    logic [2:0]          pcnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;
    logic [7:0]          out_byte_next;
    logic                last_reg;
    logic                last_next;
    logic                eos_reg;
    logic                eos_next;

    logic [7:0]          pend8;
    logic [3:0]          take;
    logic [7:0]          avail;
    logic [7:0]          pend_al;
    logic                will_emit;
    logic                can_emit;
    logic                step;
    logic                done;

    assign pend8     = {1'b0, pend_reg};
    assign take      = 4'd8 - {1'b0, pcnt_reg};
    assign avail     = {5'b0, pcnt_reg} + {1'b0, rem_reg};
    assign pend_al   = pend8 << take;
    assign will_emit = flush_reg ? (pcnt_reg != 3'd0) : (avail >= 8'd8);
    assign can_emit  = !out_valid_reg || out_ready;
    assign step      = (state_reg == BK_RUN) && (!will_emit || can_emit);
    assign done      = step && (flush_reg || !will_emit);

    assign q_ready       = (state_reg == BK_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_item  = last_reg;
    assign end_of_stream = eos_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        flush_next     = flush_reg;
        pend_next      = pend_reg;
        pcnt_next      = pcnt_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        eos_next       = eos_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (state_reg == BK_IDLE && q_valid)
        begin
            sh_next    = q_data.bits;
            rem_next   = q_data.len;
            flush_next = q_data.flush;
        end

        if (step)
        begin
            if (flush_reg)
            begin
                if (will_emit)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_al;
                    last_next      = 1'b1;
                    eos_next       = 1'b1;
                end
                pend_next = '0;
                pcnt_next = '0;
            end
            else if (will_emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_al | (sh_reg[STREAM_W-1 -: 8] >> pcnt_reg);
                last_next      = (avail < 8'd16);
                eos_next       = 1'b0;
                sh_next        = sh_reg << take;
                rem_next       = rem_reg - 7'(take);
                pend_next      = '0;
                pcnt_next      = '0;
            end
            else
            begin
                // Fewer than eight bits remain, so they join the carried bits.
                pend_next = 7'((pend8 << rem_reg[2:0])
                          | (sh_reg[STREAM_W-1 -: 8] >> (4'd8 - {1'b0, rem_reg[2:0]})));
                pcnt_next = pcnt_reg + rem_reg[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pend_reg      <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        flush_reg    <= flush_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        eos_reg      <= eos_next;
    end

endmodule

// ===== sv/cie_checker.sv =====
`include "compressed_int_bit_encoder_macros.svh"

module cie_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        last_of_item,
    input logic        end_of_stream
);

    logic [9:0] out_fields;
    logic       out_xfer;

    assign out_fields = {out_byte, last_of_item, end_of_stream};
    assign out_xfer   = out_valid && out_ready;

    // A stalled output transfer keeps its byte and flags.
    `CIE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

    // A flush gives a single byte, so it is always the last of its item.
    `CIE_ASSERT_SAME(a_eos_is_last, out_valid && end_of_stream, last_of_item)

    // After a byte that is not the last of an encode item, a flush byte cannot follow at once.
    `CIE_ASSERT_NEXT(a_no_eos_mid_item, out_xfer && !last_of_item, !(out_valid && end_of_stream))

endmodule

bind compressed_int_bit_encoder cie_checker u_checker (.*);

// ===== bench/tb_compressed_int_bit_encoder.sv =====
module tb_compressed_int_bit_encoder;
    import cie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       eos;
    } coded_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = MODE_ENCODE;
    logic [63:0] value = '0;
    logic [3:0]  size_bytes = 4'd1;
    logic        is_signed = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_item;
    logic        end_of_stream;

    logic [6:0]  carry_bits = '0;
    logic [2:0]  carry_count = '0;
    coded_byte_t expected_bytes[$];
    coded_byte_t want;
    int          mismatch_count = 0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int          hold_off_cycles = 0;

    compressed_int_bit_encoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value         (value),
        .size_bytes    (size_bytes),
        .is_signed     (is_signed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_item  (last_of_item),
        .end_of_stream (end_of_stream)
    );

    always #6 clk = ~clk;

    task automatic shift_in_bit(input logic b);
        logic [7:0]  acc;
        coded_byte_t done_byte;
        acc = {carry_bits, b};
        if (carry_count == 3'd7)
        begin
            done_byte.data = acc;
            done_byte.last = 1'b0;
            done_byte.eos  = 1'b0;
            expected_bytes.push_back(done_byte);
            carry_bits  = '0;
            carry_count = '0;
        end
        else
        begin
            carry_bits  = acc[6:0];
            carry_count = carry_count + 3'd1;
        end
    endtask

    task automatic shift_in_field(input logic [7:0] v, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            shift_in_bit(v[i]);
    endtask

    task automatic predict_item(input logic m, input logic [63:0] v, input logic [3:0] sz,
                                input logic sg);
        int          n0;
        int          nbytes;
        int          top;
        logic        found;
        logic [7:0]  fill;
        logic [7:0]  pad;
        coded_byte_t tail;
        n0 = expected_bytes.size();
        if (m == MODE_FLUSH)
        begin
            if (carry_count != 3'd0)
            begin
                pad = {1'b0, carry_bits};
                pad = pad << (8 - carry_count);
                tail.data = pad;
                tail.last = 1'b0;
                tail.eos  = 1'b1;
                expected_bytes.push_back(tail);
                carry_bits  = '0;
                carry_count = '0;
            end
        end
        else
        begin
            nbytes = int'(sz);
            if (nbytes == 0)
                nbytes = 1;
            if (nbytes > MAX_VALUE_BYTES)
                nbytes = MAX_VALUE_BYTES;
            fill  = sg ? 8'hFF : 8'h00;
            found = 1'b0;
            top   = nbytes - 1;
            while (top > 0 && !found)
            begin
                if (v[top*8 +: 8] == fill)
                begin
                    shift_in_bit(1'b1);
                    top--;
                end
                else
                    found = 1'b1;
            end
            if (found)
            begin
                shift_in_bit(1'b0);
                for (int k = 0; k <= top; k++)
                    shift_in_field(v[k*8 +: 8], 8);
            end
            else if (v[7:4] == fill[7:4])
            begin
                shift_in_bit(1'b1);
                shift_in_field({4'h0, v[3:0]}, 4);
            end
            else
            begin
                shift_in_bit(1'b0);
                shift_in_field(v[7:0], 8);
            end
        end
        if (expected_bytes.size() > n0)
        begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            carry_bits  = '0;
            carry_count = '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_item(mode, value, size_bytes, is_signed);
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual %h last %b eos %b",
                             $time, out_byte, last_of_item, end_of_stream);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.data, out_byte);
                        mismatch_count++;
                    end
                    if (last_of_item !== want.last)
                    begin
                        $display("%0t: last_of_item expected %b actual %b",
                                 $time, want.last, last_of_item);
                        mismatch_count++;
                    end
                    if (end_of_stream !== want.eos)
                    begin
                        $display("%0t: end_of_stream expected %b actual %b",
                                 $time, want.eos, end_of_stream);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (rx_idle_on)
                out_ready <= ($urandom_range(99) >= 17);
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic m, input logic [63:0] v, input logic [3:0] sz,
                             input logic sg);
        if (tx_idle_on)
        begin
            while ($urandom_range(99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        mode       <= m;
        value      <= v;
        size_bytes <= sz;
        is_signed  <= sg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        logic [63:0] v;
        logic [3:0]  sz;
        logic        sg;
        int          keep;
        v  = {$urandom, $urandom};
        sg = 1'($urandom_range(1));
        if ($urandom_range(99) < 8)
        begin
            send_item(MODE_FLUSH, v, 4'($urandom_range(15)), sg);
        end
        else
        begin
            sz = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
            keep = $urandom_range(8);
            for (int i = 0; i < 8; i++)
                if (i >= keep)
                    v[i*8 +: 8] = sg ? 8'hFF : 8'h00;
            if ($urandom_range(3) == 0)
                v[7:4] = sg ? 4'hF : 4'h0;
            send_item(MODE_ENCODE, v, sz, sg);
        end
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_item(MODE_FLUSH, 64'h0, 4'd1, 1'b0);
        send_item(MODE_ENCODE, 64'h0, 4'd1, 1'b0);
        send_item(MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send_item(MODE_FLUSH, 64'h0, 4'd0, 1'b0);
        send_item(MODE_ENCODE, 64'h0F, 4'd1, 1'b0);
        send_item(MODE_ENCODE, 64'h10, 4'd1, 1'b0);
        send_item(MODE_ENCODE, 64'hFF, 4'd1, 1'b0);
        send_item(MODE_ENCODE, 64'hFF, 4'd1, 1'b1);
        send_item(MODE_ENCODE, 64'hF0, 4'd1, 1'b1);
        send_item(MODE_ENCODE, 64'h7F, 4'd1, 1'b1);
        send_item(MODE_ENCODE, 64'h0, 4'd8, 1'b0);
        send_item(MODE_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_item(MODE_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        send_item(MODE_ENCODE, 64'h8000_0000_0000_0000, 4'd8, 1'b1);
        send_item(MODE_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        send_item(MODE_ENCODE, 64'hDEAD_BEEF_CAFE_0012, 4'd2, 1'b0);
        send_item(MODE_ENCODE, 64'h1234_5678_FFFF_FF80, 4'd4, 1'b1);
        send_item(MODE_ENCODE, 64'hABCD_EF01_2345_6705, 4'd0, 1'b0);
        send_item(MODE_ENCODE, 64'h0000_0000_0012_3456, 4'd15, 1'b0);
        send_item(MODE_ENCODE, 64'hFFFF_FFFF_FFFF_FF01, 4'd9, 1'b1);
        send_item(MODE_FLUSH, 64'h5A5A_5A5A_5A5A_5A5A, 4'd7, 1'b1);
        wait_for_idle();
    endtask

    task automatic test_random_stream(input int count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count) send_random_item();
        wait_for_idle();
    endtask

    task automatic test_unbroken_stream(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count) send_random_item();
        wait_for_idle();
    endtask

    // The receiver refuses every transfer for a long stretch, so the input side must stall.
    task automatic test_output_backpressure(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        hold_off_cycles = 200;
        repeat (count) send_random_item();
        wait_for_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_stream(300);
        test_unbroken_stream(120);
        test_output_backpressure(60);
        if (mismatch_count == 0)
            $display("PASS compressed_int_bit_encoder");
        else
            $display("FAIL compressed_int_bit_encoder");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAIL compressed_int_bit_encoder");
        $finish;
    end

endmodule

// ===== compressed_int_bit_encoder.f =====
+incdir+sv
sv/cie_pkg.sv
sv/cie_front.sv
sv/cie_queue.sv
sv/cie_back.sv
sv/compressed_int_bit_encoder.sv
sv/cie_checker.sv
bench/tb_compressed_int_bit_encoder.sv
